>>> hw/rtl/srmp_pkg.sv
// srmp_pkg: types, constants and the color palette of the star-path ray-march pixel block
// used by srmp_cell and starpath_ray_march_pixel_top; depends on nothing else
`default_nettype none

package srmp_pkg;

   localparam int COLUMN_W = 6;
   localparam int ROW_W    = 6;
   localparam int FRAME_W  = 8;
   localparam int COLOR_W  = 4;

   localparam int COL6_W   = 9;   // column*6, up to 378
   localparam int ROW4_W   = 8;   // row*4, up to 252
   localparam int DEPTH_W  = 9;   // march ends once depth passes column*6
   localparam int XPROD_W  = 16;
   localparam int YPROD_W  = 17;
   localparam int HI_W     = 9;
   localparam int SUM_W    = 10;
   localparam int IDX_W    = 5;
   localparam int RES_W    = 9;

   localparam logic [DEPTH_W-1:0] START_DEPTH = 9'd14;
   localparam logic [SUM_W-1:0]   HIT_LIMIT   = 10'd16;
   localparam logic [IDX_W-1:0]   HIT_OFFSET  = 5'd16;
   localparam logic [IDX_W-1:0]   STAR_INDEX  = 5'd15;
   localparam logic [RES_W-1:0]   STAR_MAX    = 9'd6;
   localparam logic [XPROD_W-1:0] XPROD_START = 16'd196;   // 14*14

   // per-item operands, fixed for the whole march
   typedef struct packed {
      logic [COL6_W-1:0]  col6;
      logic [ROW4_W-1:0]  row4;
      logic [FRAME_W-1:0] frame;
   } operand_type;

   // march state carried from cell to cell
   typedef struct packed {
      logic               valid;
      logic               done;
      logic [DEPTH_W-1:0] depth;
      logic [XPROD_W-1:0] xprod;
      logic [YPROD_W-1:0] yprod;
      logic [IDX_W-1:0]   idx;
   } march_type;

   function automatic logic [COLOR_W-1:0] palette(input logic [IDX_W-1:0] idx);
      logic [COLOR_W-1:0] color;
      case (idx)
         5'd0:  color = 4'd0;
         5'd1:  color = 4'd5;
         5'd2:  color = 4'd0;
         5'd3:  color = 4'd5;
         5'd4:  color = 4'd5;
         5'd5:  color = 4'd5;
         5'd6:  color = 4'd10;
         5'd7:  color = 4'd10;
         5'd8:  color = 4'd5;
         5'd9:  color = 4'd5;
         5'd10: color = 4'd10;
         5'd11: color = 4'd10;
         5'd12: color = 4'd7;
         5'd13: color = 4'd7;
         5'd14: color = 4'd15;
         5'd15: color = 4'd15;
         5'd16: color = 4'd1;
         5'd17: color = 4'd2;
         5'd18: color = 4'd1;
         5'd19: color = 4'd2;
         5'd20: color = 4'd3;
         5'd21: color = 4'd9;
         5'd22: color = 4'd3;
         5'd23: color = 4'd9;
         5'd24: color = 4'd13;
         5'd25: color = 4'd12;
         5'd26: color = 4'd13;
         5'd27: color = 4'd12;
         5'd28: color = 4'd4;
         5'd29: color = 4'd4;
         5'd30: color = 4'd4;
         5'd31: color = 4'd4;
         default: color = 4'd0;
      endcase
      return color;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srmp_cell.sv
// srmp_cell: one cell of the march ring, does one depth step and holds the result
// depends on srmp_pkg
`default_nettype none

module srmp_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  srmp_pkg::operand_type opnd,
   input  srmp_pkg::march_type  slot_in,
   output srmp_pkg::march_type  slot_ff
);

   srmp_pkg::march_type             slot_in_next;
   logic [srmp_pkg::YPROD_W-1:0]    sky_v;
   logic [srmp_pkg::RES_W-1:0]      sky_res;
   logic                            star;
   logic [srmp_pkg::HI_W-1:0]       hi;
   logic [srmp_pkg::SUM_W-1:0]      depth_sum;
   logic [srmp_pkg::SUM_W-1:0]      hit;
   logic [srmp_pkg::XPROD_W-1:0]    xdelta;

   always_comb begin
      // residue in 1..256, never zero; a zero sum gives 256
      sky_v   = srmp_pkg::YPROD_W'(opnd.col6) + slot_in.yprod;
      sky_res = {1'b0, 8'(sky_v - 1'b1)} + 1'b1;
      star    = (sky_v == '0) || (sky_res <= srmp_pkg::STAR_MAX);

      hi        = srmp_pkg::HI_W'(slot_in.xprod[srmp_pkg::XPROD_W-1:8])
                  | slot_in.yprod[srmp_pkg::YPROD_W-1:8];
      depth_sum = srmp_pkg::SUM_W'(slot_in.depth) + srmp_pkg::SUM_W'(opnd.frame);
      hit       = srmp_pkg::SUM_W'(hi) & depth_sum;
      // (c6-d-1)*(d+1) - (c6-d)*d = c6 - 2d - 1, kept modulo 2^16
      xdelta    = srmp_pkg::XPROD_W'(opnd.col6)
                  - srmp_pkg::XPROD_W'({slot_in.depth, 1'b0}) - 1'b1;

      slot_in_next = slot_in;
      if (slot_in.valid && !slot_in.done) begin
         if (opnd.col6 < srmp_pkg::COL6_W'(slot_in.depth)) begin
            slot_in_next.done = 1'b1;
            slot_in_next.idx  = star ? srmp_pkg::STAR_INDEX
                                     : {1'b1, opnd.row4[srmp_pkg::ROW4_W-1:4]};
         end else begin
            slot_in_next.depth = slot_in.depth + 1'b1;
            slot_in_next.xprod = slot_in.xprod + xdelta;
            slot_in_next.yprod = slot_in.yprod + srmp_pkg::YPROD_W'(opnd.row4);
            if (hit >= srmp_pkg::HIT_LIMIT) begin
               slot_in_next.done = 1'b1;
               slot_in_next.idx  = hit[srmp_pkg::IDX_W-1:0] - srmp_pkg::HIT_OFFSET;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         slot_ff.done  <= 1'b0;
      end else if (advance) begin
         slot_ff.valid <= slot_in_next.valid;
         slot_ff.done  <= slot_in_next.done;
      end
      if (advance) begin
         slot_ff.depth <= slot_in_next.depth;
         slot_ff.xprod <= slot_in_next.xprod;
         slot_ff.yprod <= slot_in_next.yprod;
         slot_ff.idx   <= slot_in_next.idx;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/starpath_ray_march_pixel_top.sv
// starpath_ray_march_pixel_top: ring of march cells, operand latch and result register
// depends on srmp_pkg and srmp_cell
//
// One pixel (column, row, frame) goes in, one 4-bit palette color comes out. The pixel
// travels around a ring of NUM_CELLS cells, one depth step per cycle, starting at depth 14,
// until it hits or reaches the sky; a pixel needs up to column*6 - 12 steps (one step for a
// column below 3), and its color is registered once the item reaches the ring exit, so an
// item always leaves the ring after a whole number of trips around it. One pixel is marched
// at a time; the next one is taken in the cycle after the color leaves the ring, while that
// color may still wait in the result register.
`default_nettype none

module starpath_ray_march_pixel_top #(
   parameter int NUM_CELLS = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [5:0] req_column,
   input  wire  [5:0] req_row,
   input  wire  [7:0] req_frame_count,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [3:0] rsp_pixel_color
);

   srmp_pkg::operand_type opnd_ff;
   srmp_pkg::operand_type opnd_in;
   srmp_pkg::march_type   head;
   srmp_pkg::march_type   start;
   srmp_pkg::march_type   slot_q [NUM_CELLS];
   srmp_pkg::march_type   last;
   logic [NUM_CELLS-1:0]  slot_valid;
   logic                  busy_ff;
   logic                  rsp_valid_ff;
   logic [srmp_pkg::COLOR_W-1:0] color_ff;
   logic                  accept;
   logic                  deliver;
   logic                  advance;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign last      = slot_q[NUM_CELLS-1];
   // a finished item at the ring exit holds the ring until the result register frees up
   assign advance   = !(last.valid && last.done && rsp_valid_ff && !rsp_ready);
   assign deliver   = last.valid && last.done && advance;

   always_comb begin
      opnd_in.col6  = (srmp_pkg::COL6_W'(req_column) << 2)
                      + (srmp_pkg::COL6_W'(req_column) << 1);
      opnd_in.row4  = {req_row, 2'b00};
      opnd_in.frame = req_frame_count;

      start.valid = 1'b1;
      start.done  = 1'b0;
      start.depth = srmp_pkg::START_DEPTH;
      // (col6 - 14) * 14 and row4 * 14, as shifts
      start.xprod = (srmp_pkg::XPROD_W'(opnd_in.col6) << 4)
                    - (srmp_pkg::XPROD_W'(opnd_in.col6) << 1) - srmp_pkg::XPROD_START;
      start.yprod = (srmp_pkg::YPROD_W'(opnd_in.row4) << 4)
                    - (srmp_pkg::YPROD_W'(opnd_in.row4) << 1);
      start.idx   = '0;

      if (accept) begin
         head = start;
      end else begin
         head       = last;
         head.valid = last.valid && !last.done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opnd_ff <= opnd_in;
      end
   end

   genvar k;
   generate
      for (k = 0; k < NUM_CELLS; k++) begin : g_cell
         if (k == 0) begin : g_head
            srmp_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .advance (advance),
               .opnd    (accept ? opnd_in : opnd_ff),
               .slot_in (head),
               .slot_ff (slot_q[k])
            );
         end else begin : g_body
            srmp_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .advance (advance),
               .opnd    (opnd_ff),
               .slot_in (slot_q[k-1]),
               .slot_ff (slot_q[k])
            );
         end
         assign slot_valid[k] = slot_q[k].valid;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (deliver) begin
            busy_ff <= 1'b0;
         end
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         color_ff <= srmp_pkg::palette(last.idx);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = color_ff;

   // only one item ever travels the ring
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid) <= 1)
      else $error("more than one item in the march ring");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (slot_valid == '0))
      else $error("ring holds an item while idle");

   a_busy_has_item: assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(busy_ff) |-> (slot_valid != '0))
      else $error("item lost from the ring");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      last.valid && !last.done |->
         (srmp_pkg::SUM_W'(last.depth) <= srmp_pkg::SUM_W'(opnd_ff.col6) + 1'b1))
      else $error("march depth passed the sky boundary");

   a_deliver_frees: assert property (@(posedge clock) disable iff (reset)
      deliver |=> rsp_valid_ff && !busy_ff)
      else $error("delivered item did not reach the result register");

endmodule

`default_nettype wire
